// File: rtl/utc_clock_with_daily_window_top_defines.svh
// Assertion macros for the UTC clock with daily window block.
// Used by the port checker; expects signals clock and reset in scope.
`ifndef UTC_CLOCK_WITH_DAILY_WINDOW_TOP_DEFINES_SVH
`define UTC_CLOCK_WITH_DAILY_WINDOW_TOP_DEFINES_SVH

// same-cycle implication
`define UTCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/utcw_pkg.sv
// Shared types, codes and constants of the UTC clock with daily window.
// No dependencies.
`default_nettype none
package utcw_pkg;

   localparam int TICKS_PER_SECOND = 32768;
   localparam int PRESCALE_W       = 16;
   localparam int SECONDS_PER_DAY  = 86400;
   localparam int DAY_SEC_W        = 17;
   localparam int MINUTE_W         = 11;
   localparam int MINUTE_MAX       = 1439;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int TZ_W             = 12;
   localparam int WIN_W            = 16;
   localparam logic [WIN_W-1:0] WINDOW_DISABLED = 16'hFFFF;

   // utc mod 86400 = ((utc >> 7) mod 675) << 7 | utc[6:0]
   localparam int DAY_ODD          = 675;
   localparam logic [22:0] DAY_ODD_RECIP = 23'(64'd4294967296 / 64'd675);
   // (x >> 2) / 15 by reciprocal, exact below 2^15
   localparam logic [16:0] DIV15_RECIP = 17'd69906;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SYNC      = 2'd1,
      OP_SUPERVISE = 2'd2,
      OP_STATUS    = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TZ_OFFSET   = 2'd0,
      CSR_WIN_START   = 2'd1,
      CSR_WIN_END     = 2'd2,
      CSR_ECO_ENABLE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        valid;
      logic        sup;
      logic        sync;
      logic        zero;
      logic [31:0] utc;
   } utcw_ctl_type;

   typedef struct packed {
      utcw_ctl_type          ctl;
      logic [MINUTE_W-1:0]   minute;
   } utcw_minute_type;

   // timezone offset in seconds, reduced into [0, 86400)
   function automatic logic [DAY_SEC_W-1:0] tz_day_sec(input logic [TZ_W-1:0] tz);
      logic signed [19:0] tz_x;
      logic signed [19:0] v;
      logic [18:0]        u;
      logic [DAY_SEC_W-1:0] r;
      tz_x = {{(20-TZ_W){tz[TZ_W-1]}}, tz};
      v    = tz_x * 20'sd60 + 20'sd172800;
      u    = v[18:0];
      if (u >= 19'd259200) begin
         r = DAY_SEC_W'(u - 19'd259200);
      end else if (u >= 19'd172800) begin
         r = DAY_SEC_W'(u - 19'd172800);
      end else if (u >= 19'd86400) begin
         r = DAY_SEC_W'(u - 19'd86400);
      end else begin
         r = DAY_SEC_W'(u);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/utcw_ifs.sv
// Request and response channel interfaces of the UTC clock block.
// Depends on utcw_pkg.
`default_nettype none
interface utcw_req_if;
   logic            valid;
   logic            ready;
   utcw_pkg::op_type op;
   logic [31:0]     epoch_in;
   modport source (output valid, output op, output epoch_in, input ready);
   modport sink   (input valid, input op, input epoch_in, output ready);
endinterface

interface utcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [31:0]                   utc_seconds;
   logic                          synced;
   logic [utcw_pkg::MINUTE_W-1:0] minute_of_day;
   logic                          in_window;
   logic                          adv_stop;
   logic                          adv_start;
   modport source (output valid, output utc_seconds, output synced, output minute_of_day,
                   output in_window, output adv_stop, output adv_start, input ready);
   modport sink   (input valid, input utc_seconds, input synced, input minute_of_day,
                   input in_window, input adv_stop, input adv_start, output ready);
endinterface
`default_nettype wire

// File: rtl/utcw_counter.sv
// Seconds counter, tick prescaler and sync flag; takes request words.
// Depends on utcw_pkg and utcw_req_if.
`default_nettype none
module utcw_counter (
   input  wire logic           clock,
   input  wire logic           reset,
   utcw_req_if.sink            req_bus,
   input  wire logic           advance,
   output utcw_pkg::utcw_ctl_type snap
);
   import utcw_pkg::*;

   logic [31:0]           seconds_ff, seconds_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic                  sync_ff, sync_in;
   logic [PRESCALE_W:0]   prescale_next;
   utcw_ctl_type          snap_ff, snap_in;
   logic                  accept;

   assign req_bus.ready = advance;
   assign accept        = req_bus.valid & advance;
   assign prescale_next = {1'b0, prescale_ff} + (PRESCALE_W+1)'(1);

   always_comb begin
      seconds_in  = seconds_ff;
      prescale_in = prescale_ff;
      sync_in     = sync_ff;
      case (req_bus.op)
         OP_TICK: begin
            if (prescale_next >= (PRESCALE_W+1)'(TICKS_PER_SECOND)) begin
               prescale_in = '0;
               seconds_in  = seconds_ff + 32'd1;
            end else begin
               prescale_in = prescale_next[PRESCALE_W-1:0];
            end
         end
         OP_SYNC: begin
            seconds_in  = req_bus.epoch_in;
            prescale_in = '0;
            sync_in     = 1'b1;
         end
         default: begin
         end
      endcase
      snap_in.valid = accept;
      snap_in.sup   = (req_bus.op == OP_SUPERVISE);
      snap_in.sync  = sync_in;
      snap_in.utc   = sync_in ? seconds_in : 32'd0;
      snap_in.zero  = (snap_in.utc == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff    <= '0;
         prescale_ff   <= '0;
         sync_ff       <= 1'b0;
         snap_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            seconds_ff  <= seconds_in;
            prescale_ff <= prescale_in;
            sync_ff     <= sync_in;
         end
         if (advance) begin
            snap_ff <= snap_in;
         end
      end
   end

   assign snap = snap_ff;
endmodule
`default_nettype wire

// File: rtl/utcw_daymod.sv
// Local minute of day pipeline: utc mod 86400 by reciprocal, add zone, divide by 60.
// Depends on utcw_pkg.
`default_nettype none
module utcw_daymod (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [utcw_pkg::TZ_W-1:0] tz_offset,
   input  wire utcw_pkg::utcw_ctl_type snap,
   output utcw_pkg::utcw_minute_type  mout
);
   import utcw_pkg::*;

   logic [DAY_SEC_W-1:0] tz_sec_ff;

   // stage 2: quotient estimate of (utc >> 7) / 675
   utcw_ctl_type         ctl2_ff;
   logic [15:0]          qh2_ff, qh2_in;
   logic [47:0]          prod1;

   // stage 3: utc seconds of day
   utcw_ctl_type         ctl3_ff;
   logic [DAY_SEC_W-1:0] day3_ff, day3_in;
   logic [25:0]          diff2;
   logic [10:0]          rem2;
   logic [9:0]           rem2_fix;

   // stage 4: local seconds of day
   utcw_ctl_type         ctl4_ff;
   logic [DAY_SEC_W-1:0] local4_ff, local4_in;
   logic [DAY_SEC_W:0]   sum3;

   // stage 5: minute
   utcw_minute_type      mout_ff, mout_in;
   logic [31:0]          prod4;

   assign prod1  = {23'd0, snap.utc[31:7]} * {25'd0, DAY_ODD_RECIP};
   assign qh2_in = prod1[47:32];

   assign diff2    = {1'b0, ctl2_ff.utc[31:7]} - 26'(qh2_ff * 26'(DAY_ODD));
   assign rem2     = diff2[10:0];
   assign rem2_fix = (rem2 >= 11'(DAY_ODD)) ? 10'(rem2 - 11'(DAY_ODD)) : rem2[9:0];
   assign day3_in  = {rem2_fix, ctl2_ff.utc[6:0]};

   assign sum3      = {1'b0, day3_ff} + {1'b0, tz_sec_ff};
   assign local4_in = (sum3 >= (DAY_SEC_W+1)'(SECONDS_PER_DAY))
                    ? DAY_SEC_W'(sum3 - (DAY_SEC_W+1)'(SECONDS_PER_DAY))
                    : sum3[DAY_SEC_W-1:0];

   assign prod4 = {17'd0, local4_ff[DAY_SEC_W-1:2]} * {15'd0, DIV15_RECIP};

   always_comb begin
      mout_in.ctl    = ctl4_ff;
      mout_in.minute = ctl4_ff.zero ? '0 : prod4[30:20];
   end

   always_ff @(posedge clock) begin
      tz_sec_ff <= tz_day_sec(tz_offset);
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         mout_ff.ctl.valid <= 1'b0;
      end else if (advance) begin
         ctl2_ff   <= snap;
         qh2_ff    <= qh2_in;
         ctl3_ff   <= ctl2_ff;
         day3_ff   <= day3_in;
         ctl4_ff   <= ctl3_ff;
         local4_ff <= local4_in;
         mout_ff   <= mout_in;
      end
   end

   assign mout = mout_ff;
endmodule
`default_nettype wire

// File: rtl/utcw_window.sv
// Eco window compare, advertising pulse state and response register.
// Depends on utcw_pkg and utcw_rsp_if.
`default_nettype none
module utcw_window (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire utcw_pkg::utcw_minute_type mout,
   input  wire logic [utcw_pkg::WIN_W-1:0] win_start,
   input  wire logic [utcw_pkg::WIN_W-1:0] win_end,
   input  wire logic                   eco_enable,
   output logic                        advance,
   utcw_rsp_if.source                  rsp_bus
);
   import utcw_pkg::*;

   logic             rsp_valid_ff;
   logic             eco_ff, eco_in;
   logic [31:0]      utc_ff;
   logic             synced_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic             win_ff, win_in;
   logic             stop_ff, stop_in;
   logic             start_ff, start_in;
   logic [WIN_W-1:0] cur;
   logic             disabled;
   logic             supervise;

   assign advance  = ~rsp_valid_ff | rsp_bus.ready;
   assign cur      = WIN_W'(mout.minute);
   assign disabled = (win_start == WINDOW_DISABLED) | (win_end == WINDOW_DISABLED);
   assign supervise = mout.ctl.valid & mout.ctl.sup & mout.ctl.sync & eco_enable;

   always_comb begin
      if (!mout.ctl.sync || disabled) begin
         win_in = 1'b0;
      end else if (win_start < win_end) begin
         win_in = (cur >= win_start) & (cur < win_end);
      end else begin
         win_in = (cur >= win_start) | (cur < win_end);
      end
      eco_in   = eco_ff;
      stop_in  = 1'b0;
      start_in = 1'b0;
      if (supervise) begin
         if (win_in && !eco_ff) begin
            stop_in = 1'b1;
            eco_in  = 1'b1;
         end else if (!win_in && eco_ff) begin
            start_in = 1'b1;
            eco_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         eco_ff       <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mout.ctl.valid;
         eco_ff       <= eco_in;
         utc_ff       <= mout.ctl.utc;
         synced_ff    <= mout.ctl.sync;
         minute_ff    <= mout.minute;
         win_ff       <= win_in;
         stop_ff      <= stop_in;
         start_ff     <= start_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.utc_seconds   = utc_ff;
   assign rsp_bus.synced        = synced_ff;
   assign rsp_bus.minute_of_day = minute_ff;
   assign rsp_bus.in_window     = win_ff;
   assign rsp_bus.adv_stop      = stop_ff;
   assign rsp_bus.adv_start     = start_ff;
endmodule
`default_nettype wire

// File: rtl/utc_clock_with_daily_window_top.sv
// UTC clock with daily eco window: top level with configuration registers.
// Depends on utcw_pkg, utcw_ifs, utcw_counter, utcw_daymod, utcw_window.
//
// Usage:
//   req_bus carries one operation word: tick, sync to epoch_in, supervise or
//   status. rsp_bus returns one status word per request, in order: UTC
//   seconds (0 until synced), sync flag, local minute of day, window flag and
//   the advertising stop/start pulses of a supervise.
//   csr_we/csr_index/csr_wdata write timezone offset, window bounds and eco
//   enable; write them only with no request in flight.
// Pipeline: a taken request passes through the counter register, two
//   reciprocal stages, zone add, divide by 60 and window compare into the
//   response register.
// Throughput: one request per cycle when not stalled; the counter update is an
//   increment and each later stage holds one multiply or add-compare.
// Reset: counter, prescaler, sync and eco state clear; registers take their
//   defaults (offset 0, window disabled, eco off); pipeline empties.
// Stall: while rsp_bus.ready is low with a response held, the whole pipeline
//   and req_bus.ready hold.
`default_nettype none
module utc_clock_with_daily_window_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   utcw_req_if.sink                               req_bus,
   utcw_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [utcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [utcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import utcw_pkg::*;

   logic [TZ_W-1:0]  tz_ff;
   logic [WIN_W-1:0] win_start_ff;
   logic [WIN_W-1:0] win_end_ff;
   logic             eco_en_ff;
   logic             advance;
   utcw_ctl_type     snap;
   utcw_minute_type  mout;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff        <= '0;
         win_start_ff <= WINDOW_DISABLED;
         win_end_ff   <= WINDOW_DISABLED;
         eco_en_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TZ_OFFSET:  tz_ff        <= csr_wdata[TZ_W-1:0];
            CSR_WIN_START:  win_start_ff <= csr_wdata[WIN_W-1:0];
            CSR_WIN_END:    win_end_ff   <= csr_wdata[WIN_W-1:0];
            CSR_ECO_ENABLE: eco_en_ff    <= csr_wdata[0];
         endcase
      end
   end

   utcw_counter u_counter (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .snap    (snap)
   );

   utcw_daymod u_daymod (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tz_offset (tz_ff),
      .snap      (snap),
      .mout      (mout)
   );

   utcw_window u_window (
      .clock      (clock),
      .reset      (reset),
      .mout       (mout),
      .win_start  (win_start_ff),
      .win_end    (win_end_ff),
      .eco_enable (eco_en_ff),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );
endmodule
`default_nettype wire

// File: rtl/utcw_checker.sv
// Port checker for the UTC clock top level, bound onto it below.
// Depends on utcw_pkg and utc_clock_with_daily_window_top_defines.svh.
`include "utc_clock_with_daily_window_top_defines.svh"
`default_nettype none
module utcw_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [31:0]                   utc_seconds,
   input wire logic                          synced,
   input wire logic [utcw_pkg::MINUTE_W-1:0] minute_of_day,
   input wire logic                          in_window,
   input wire logic                          adv_stop,
   input wire logic                          adv_start
);
   import utcw_pkg::*;

   `UTCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(utc_seconds) && $stable(minute_of_day) && $stable(adv_stop),
      "response word changed while stalled")
   `UTCW_ASSERT_NOW(a_stop_inside, rsp_valid && adv_stop, in_window && synced && !adv_start,
      "stop pulse outside the window")
   `UTCW_ASSERT_NOW(a_start_outside, rsp_valid && adv_start, !in_window && synced,
      "start pulse inside the window")
   `UTCW_ASSERT_NOW(a_unsynced_zero, rsp_valid && !synced,
      utc_seconds == 32'd0 && minute_of_day == '0 && !in_window,
      "unsynced word carries time")
   `UTCW_ASSERT_NOW(a_minute_range, rsp_valid, minute_of_day <= MINUTE_W'(MINUTE_MAX),
      "minute of day out of range")
endmodule

bind utc_clock_with_daily_window_top utcw_checker u_utcw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .utc_seconds   (rsp_bus.utc_seconds),
   .synced        (rsp_bus.synced),
   .minute_of_day (rsp_bus.minute_of_day),
   .in_window     (rsp_bus.in_window),
   .adv_stop      (rsp_bus.adv_stop),
   .adv_start     (rsp_bus.adv_start)
);
`default_nettype wire

// File: dv/utc_clock_with_daily_window_top_tb.sv
// Self-checking testbench for the UTC clock with daily eco window.
// Drives tick, sync, supervise and status words, predicts every status word
// in order, and compares them field by field. Depends on utcw_pkg and utcw_ifs.
module utc_clock_with_daily_window_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import utcw_pkg::*;

   typedef struct packed {
      logic [31:0]         utc;
      logic                synced;
      logic [MINUTE_W-1:0] minute;
      logic                in_win;
      logic                stop;
      logic                start;
   } status_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   utcw_req_if req_bus ();
   utcw_rsp_if rsp_bus ();

   utc_clock_with_daily_window_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   status_word_type expected_words[$];

   // clock state and register copies
   logic [31:0]     seconds_q;
   logic [15:0]     prescale_q;
   logic            synced_q;
   logic            eco_active_q;
   logic [TZ_W-1:0] tz_q;
   logic [15:0]     win_start_q;
   logic [15:0]     win_end_q;
   logic            eco_en_q;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic [MINUTE_W-1:0] local_minute();
      longint tz;
      longint local_sec;
      longint day_sec;
      if (!synced_q || seconds_q == 32'd0) return '0;
      tz = longint'($signed(tz_q));
      local_sec = longint'({32'd0, seconds_q}) + tz * 60;
      day_sec = local_sec % 86400;
      if (day_sec < 0) day_sec += 86400;
      return MINUTE_W'(day_sec / 60);
   endfunction

   function automatic bit in_eco_window();
      logic [15:0] cur;
      if (!synced_q) return 1'b0;
      if (win_start_q == WINDOW_DISABLED || win_end_q == WINDOW_DISABLED) return 1'b0;
      cur = {5'd0, local_minute()};
      if (win_start_q < win_end_q) return (cur >= win_start_q) && (cur < win_end_q);
      return (cur >= win_start_q) || (cur < win_end_q);
   endfunction

   function automatic status_word_type advance_clock(op_type op, logic [31:0] epoch);
      status_word_type w;
      logic [16:0] nxt;
      bit win;
      w = '0;
      case (op)
         OP_TICK: begin
            nxt = {1'b0, prescale_q} + 17'd1;
            if (nxt >= TICKS_PER_SECOND) begin
               prescale_q = '0;
               seconds_q = seconds_q + 32'd1;
            end else begin
               prescale_q = nxt[15:0];
            end
         end
         OP_SYNC: begin
            seconds_q = epoch;
            prescale_q = '0;
            synced_q = 1'b1;
         end
         default: ;
      endcase
      win = in_eco_window();
      if (op == OP_SUPERVISE && synced_q && eco_en_q) begin
         if (win) begin
            if (!eco_active_q) begin
               w.stop = 1'b1;
               eco_active_q = 1'b1;
            end
         end else if (eco_active_q) begin
            w.start = 1'b1;
            eco_active_q = 1'b0;
         end
      end
      w.utc = synced_q ? seconds_q : 32'd0;
      w.synced = synced_q;
      w.minute = local_minute();
      w.in_win = win;
      return w;
   endfunction

   always @(posedge clock) begin
      status_word_type got;
      status_word_type want;
      bit unexpected;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.utc = rsp_bus.utc_seconds;
         got.synced = rsp_bus.synced;
         got.minute = rsp_bus.minute_of_day;
         got.in_win = rsp_bus.in_window;
         got.stop = rsp_bus.adv_stop;
         got.start = rsp_bus.adv_start;
         unexpected = (expected_words.size() == 0);
         want = unexpected ? '0 : expected_words.pop_front();
         if (unexpected || got.utc !== want.utc || got.synced !== want.synced ||
             got.minute !== want.minute || got.in_win !== want.in_win ||
             got.stop !== want.stop || got.start !== want.start) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t status word%s exp utc=%h sync=%b min=%0d win=%b stop=%b start=%b",
                        $realtime, unexpected ? " (none expected)" : "",
                        want.utc, want.synced, want.minute, want.in_win, want.stop,
                        want.start);
               $display("   got utc=%h sync=%b min=%0d win=%b stop=%b start=%b",
                        got.utc, got.synced, got.minute, got.in_win, got.stop, got.start);
            end
         end
      end
   end

   task automatic send_word(op_type op, logic [31:0] epoch);
      bit idled;
      idled = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         if (!idled) req_bus.valid <= 1'b0;
         idled = 1'b1;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.epoch_in <= epoch;
      do @(posedge clock); while (!req_bus.ready);
      expected_words.push_back(advance_clock(op, epoch));
   endtask

   // hold the sender until every status word is back
   task automatic drain_words();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_TZ_OFFSET:  tz_q = data[TZ_W-1:0];
         CSR_WIN_START:  win_start_q = data;
         CSR_WIN_END:    win_end_q = data;
         CSR_ECO_ENABLE: eco_en_q = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // epoch whose local minute lands within two minutes of a window bound
   function automatic logic [31:0] epoch_near(logic [15:0] bound);
      longint m;
      longint e;
      m = (longint'(bound) + longint'($urandom_range(0, 4)) + 1438) % 1440;
      e = longint'($urandom_range(1, 49000)) * 86400 + m * 60 +
          longint'($urandom_range(0, 59)) - longint'($signed(tz_q)) * 60;
      return e[31:0];
   endfunction

   task automatic random_settings();
      logic [TZ_W-1:0] tz;
      logic [15:0] ws;
      logic [15:0] we;
      int k;
      case ($urandom_range(0, 7))
         0: tz = 12'h800;
         1: tz = 12'h7FF;
         2: tz = 12'hA60;
         3: tz = 12'h5A0;
         4: tz = 12'h000;
         default: tz = TZ_W'($urandom);
      endcase
      k = $urandom_range(0, 9);
      ws = 16'($urandom_range(0, MINUTE_MAX));
      we = 16'($urandom_range(0, MINUTE_MAX));
      case (k)
         6: we = ws;
         7: if ($urandom_range(0, 1)) ws = WINDOW_DISABLED; else we = WINDOW_DISABLED;
         8: begin
            ws = 16'($urandom);
            we = 16'($urandom);
         end
         9: begin
            ws = 16'd0;
            we = 16'(MINUTE_MAX);
         end
         default: ;
      endcase
      write_reg(CSR_TZ_OFFSET, {4'($urandom), tz});
      write_reg(CSR_WIN_START, ws);
      write_reg(CSR_WIN_END, we);
      write_reg(CSR_ECO_ENABLE, {15'($urandom), 1'($urandom_range(0, 99) < 85)});
   endtask

   task automatic test_reset_state();
      send_word(OP_STATUS, 32'hFFFF_FFFF);
      send_word(OP_TICK, 32'hFFFF_FFFF);
      send_word(OP_SUPERVISE, 32'h0000_0000);
   endtask

   task automatic test_window_pulses();
      drain_words();
      write_reg(CSR_TZ_OFFSET, 16'hF000);
      write_reg(CSR_WIN_START, 16'd600);
      write_reg(CSR_WIN_END, 16'd660);
      write_reg(CSR_ECO_ENABLE, 16'hFFFF);
      send_word(OP_SUPERVISE, $urandom);
      send_word(OP_SYNC, 32'd0);
      send_word(OP_SYNC, 32'd36000);
      send_word(OP_SUPERVISE, $urandom);
      send_word(OP_SUPERVISE, $urandom);
      send_word(OP_SYNC, 32'd39600);
      send_word(OP_SUPERVISE, $urandom);
      send_word(OP_SYNC, 32'd39599);
      send_word(OP_SUPERVISE, $urandom);

      drain_words();
      write_reg(CSR_ECO_ENABLE, 16'hFFFE);
      send_word(OP_SYNC, 32'd0);
      send_word(OP_SUPERVISE, $urandom);

      drain_words();
      write_reg(CSR_TZ_OFFSET, 16'h0800);
      write_reg(CSR_WIN_START, 16'd1380);
      write_reg(CSR_WIN_END, 16'd60);
      write_reg(CSR_ECO_ENABLE, 16'h0001);
      send_word(OP_SYNC, 32'd100);
      send_word(OP_SUPERVISE, $urandom);
      send_word(OP_SYNC, 32'hFFFF_FFFF);
      send_word(OP_SUPERVISE, $urandom);

      drain_words();
      write_reg(CSR_TZ_OFFSET, 16'h07FF);
      write_reg(CSR_WIN_START, 16'd300);
      write_reg(CSR_WIN_END, 16'd300);
      send_word(OP_SYNC, 32'd0);
      send_word(OP_SUPERVISE, $urandom);

      drain_words();
      write_reg(CSR_WIN_START, WINDOW_DISABLED);
      write_reg(CSR_WIN_END, 16'd5);
      send_word(OP_SUPERVISE, $urandom);

      drain_words();
      write_reg(CSR_WIN_START, 16'd2000);
      write_reg(CSR_WIN_END, 16'd65534);
      send_word(OP_SYNC, 32'd1234567);
      send_word(OP_SUPERVISE, $urandom);
   endtask

   task automatic test_tick_prescale();
      drain_words();
      write_reg(CSR_TZ_OFFSET, 16'h0000);
      repeat (100) send_word(OP_TICK, $urandom);
      send_word(OP_SYNC, 32'd86399);
      repeat (100) send_word(OP_TICK, $urandom);
      send_word(OP_SYNC, 32'hFFFF_FFFF);
      repeat (50) send_word(OP_TICK, $urandom);
   endtask

   task automatic test_random_traffic(int segments, int per_segment);
      int r;
      op_type op;
      logic [31:0] epoch;
      for (int s = 0; s < segments; s++) begin
         drain_words();
         case (s % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         random_settings();
         for (int i = 0; i < per_segment; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) op = OP_SYNC;
            else if (r < 60) op = OP_SUPERVISE;
            else if (r < 85) op = OP_TICK;
            else op = OP_STATUS;
            epoch = $urandom;
            if (op == OP_SYNC) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: epoch = epoch_near(win_start_q);
                  4, 5, 6:    epoch = epoch_near(win_end_q);
                  8:          epoch = 32'd0;
                  9:          epoch = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
                  default: ;
               endcase
            end
            send_word(op, epoch);
            if ($urandom_range(0, 63) == 0) drain_words();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_STATUS;
      req_bus.epoch_in = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      seconds_q = '0;
      prescale_q = '0;
      synced_q = 1'b0;
      eco_active_q = 1'b0;
      tz_q = '0;
      win_start_q = WINDOW_DISABLED;
      win_end_q = WINDOW_DISABLED;
      eco_en_q = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_window_pulses();
      test_tick_prescale();
      test_random_traffic(8, 120);

      drain_words();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
